>>> design/assert_macros.svh
// assertion helpers for the rtl files, included by interval_bin_splitter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true at a clock edge out of reset
`define ASSERT_NEVER_CLK(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> design/ibs_pkg.sv
// ----------------------------------------------------------------------------
// ibs_pkg
// types, codes and constants of the interval bin splitter
// ----------------------------------------------------------------------------
`default_nettype none

package ibs_pkg;

	localparam int COORD_W    = 31;
	localparam int LEN_W      = 32;
	localparam int TAG_W      = 8;
	localparam int STAT_W     = 3;
	localparam int MAX_BINS_DEF = 63;

	// operations
	localparam logic OP_COUNT = 1'b0;
	localparam logic OP_SIZE  = 1'b1;

	// leftover policies
	localparam logic [1:0] POL_STRICT = 2'd0;
	localparam logic [1:0] POL_EXTEND = 2'd1;
	localparam logic [1:0] POL_ADD    = 2'd2;
	localparam logic [1:0] POL_IGNORE = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
	localparam logic [STAT_W-1:0] STAT_SHORT  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_STRICT = 3'd2;
	localparam logic [STAT_W-1:0] STAT_ZERO   = 3'd3;
	localparam logic [STAT_W-1:0] STAT_BAD    = 3'd4;

	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] site_start;
		logic [COORD_W-1:0] site_end;
		logic [COORD_W-1:0] amount;
		logic [1:0]         policy;
		logic [TAG_W-1:0]   chrom_tag;
	} ibs_req_t;

	typedef struct packed {
		logic [COORD_W-1:0] bin_start;
		logic [COORD_W-1:0] bin_end;
		logic [TAG_W-1:0]   bin_tag;
		logic [STAT_W-1:0]  status;
		logic               last_bin;
	} ibs_res_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic               done;
		logic [LEN_W-1:0]   quot;
		logic [COORD_W-1:0] rem;
	} ibs_div_res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRE,
		S_LEN,
		S_DIV,
		S_EMIT,
		S_EXTRA,
		S_ERR
	} ibs_state_t;

endpackage

`default_nettype wire

>>> design/ibs_div.sv
// ----------------------------------------------------------------------------
// ibs_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ibs_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       go,
	input  wire logic [ibs_pkg::LEN_W-1:0]  dividend,
	input  wire logic [ibs_pkg::COORD_W-1:0] divisor,
	output ibs_pkg::ibs_div_res_t           res
);

	localparam int CNT_W = $clog2(ibs_pkg::LEN_W);

	logic [CNT_W-1:0]            cnt_q;
	logic                        run_q;
	logic                        done_q;
	logic [ibs_pkg::LEN_W-1:0]   quot_q;
	logic [ibs_pkg::COORD_W-1:0] rem_q;
	logic [ibs_pkg::COORD_W-1:0] dvs_q;

	logic [ibs_pkg::LEN_W-1:0]   trial;
	logic [ibs_pkg::LEN_W-1:0]   diff;
	logic                        ge;

	// partial remainder with the next dividend bit shifted in
	assign trial = {rem_q, quot_q[ibs_pkg::LEN_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ibs_pkg::LEN_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[ibs_pkg::LEN_W-2:0], ge};
			rem_q  <= ge ? diff[ibs_pkg::COORD_W-1:0] : trial[ibs_pkg::COORD_W-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = rem_q;

endmodule

`default_nettype wire

>>> design/interval_bin_splitter.sv
// ----------------------------------------------------------------------------
// interval_bin_splitter
// cuts a closed coordinate interval into bins, one result per bin
// ----------------------------------------------------------------------------
// usage
//  - input: drive req and raise start; the item is taken at a clock edge where
//    start is high and busy is low. busy stays high until the item's last
//    result has been issued
//  - output: each result shows on res for exactly one cycle with res_valid
//    high; there is no backpressure, the receiver must take every result
//  - op 0 splits into amount equal bins, op 1 into bins of size amount;
//    the leftover follows policy (strict, extend last, add extra, ignore)
//  - errors give a single result with the status code and last_bin set
//  - timing: the interval checks run in states S_PRE and S_LEN after acceptance;
//    an error found there is issued from S_ERR. an item that reaches the
//    32-step bit-serial divider waits in S_DIV, then has its results issued
//    from S_EMIT (and S_EXTRA for an added bin), one bin per cycle; a
//    divider-stage error is issued from S_ERR. the next item can be taken
//    once the item's last result is on res
//  - reset clears the sequencer and the result strobe; no item is in flight
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module interval_bin_splitter #(
	parameter int MAX_BINS = ibs_pkg::MAX_BINS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output logic           busy,
	input  wire ibs_pkg::ibs_req_t req,
	output logic           res_valid,
	output ibs_pkg::ibs_res_t res
);

	localparam int CNT_W = $clog2(MAX_BINS + 1);
	localparam int LW    = ibs_pkg::LEN_W;
	localparam int CW    = ibs_pkg::COORD_W;

	ibs_pkg::ibs_state_t state_q, state_d;

	// captured item
	ibs_pkg::ibs_req_t req_q;

	// working registers
	logic [LW-1:0]                 len_q;
	logic [ibs_pkg::STAT_W-1:0]    err_q;
	logic [LW-1:0]                 cur_q;
	logic [LW-1:0]                 size_q;
	logic [CNT_W-1:0]              nleft_q;
	logic                          extend_q;
	logic                          extra_q;

	// registered result
	ibs_pkg::ibs_res_t             res_q, res_d;
	logic                          res_valid_q, res_valid_d;

	ibs_pkg::ibs_div_res_t         div_res;
	logic                          div_go;

	logic                          accept;
	logic                          short_c;
	logic [LW-1:0]                 count_c;
	logic [LW-1:0]                 size_c;
	logic                          rem_nz;
	logic                          strict_c;
	logic                          many_c;
	logic                          last_reg;
	logic [LW-1:0]                 reg_end;

	assign accept = start && !busy;
	assign busy   = state_q != ibs_pkg::S_IDLE;

	// length check against the amount, either op
	assign short_c = len_q < {1'b0, req_q.amount};
	assign div_go  = state_q == ibs_pkg::S_LEN && err_q == ibs_pkg::STAT_OK && !short_c;

	ibs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (len_q),
		.divisor  (req_q.amount),
		.res      (div_res)
	);

	// bin count and size from the quotient
	assign count_c  = (req_q.op == ibs_pkg::OP_SIZE) ? div_res.quot : {1'b0, req_q.amount};
	assign size_c   = (req_q.op == ibs_pkg::OP_SIZE) ? {1'b0, req_q.amount} : div_res.quot;
	assign rem_nz   = div_res.rem != '0;
	assign strict_c = req_q.policy == ibs_pkg::POL_STRICT && rem_nz;
	assign many_c   = count_c > LW'(MAX_BINS);

	// emission helpers
	assign last_reg = nleft_q == CNT_W'(1);
	assign reg_end  = cur_q + size_q - LW'(1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ibs_pkg::S_IDLE: begin
				if (accept) state_d = ibs_pkg::S_PRE;
			end
			ibs_pkg::S_PRE: begin
				state_d = ibs_pkg::S_LEN;
			end
			ibs_pkg::S_LEN: begin
				if (err_q != ibs_pkg::STAT_OK || short_c) state_d = ibs_pkg::S_ERR;
				else state_d = ibs_pkg::S_DIV;
			end
			ibs_pkg::S_DIV: begin
				if (div_res.done) begin
					if (strict_c || many_c) state_d = ibs_pkg::S_ERR;
					else state_d = ibs_pkg::S_EMIT;
				end
			end
			ibs_pkg::S_EMIT: begin
				if (last_reg) state_d = extra_q ? ibs_pkg::S_EXTRA : ibs_pkg::S_IDLE;
			end
			ibs_pkg::S_EXTRA: begin
				state_d = ibs_pkg::S_IDLE;
			end
			ibs_pkg::S_ERR: begin
				state_d = ibs_pkg::S_IDLE;
			end
			default: begin
				state_d = ibs_pkg::S_IDLE;
			end
		endcase
	end

	// result of the current cycle
	always_comb begin
		res_d       = '0;
		res_valid_d = 1'b0;
		res_d.bin_tag = req_q.chrom_tag;
		unique case (state_q)
			ibs_pkg::S_EMIT: begin
				res_valid_d     = 1'b1;
				res_d.bin_start = cur_q[CW-1:0];
				// extend policy stretches the final regular bin to the interval end
				res_d.bin_end   = (last_reg && extend_q) ? req_q.site_end : reg_end[CW-1:0];
				res_d.status    = ibs_pkg::STAT_OK;
				res_d.last_bin  = last_reg && !extra_q;
			end
			ibs_pkg::S_EXTRA: begin
				res_valid_d     = 1'b1;
				res_d.bin_start = cur_q[CW-1:0];
				res_d.bin_end   = req_q.site_end;
				res_d.status    = ibs_pkg::STAT_OK;
				res_d.last_bin  = 1'b1;
			end
			ibs_pkg::S_ERR: begin
				res_valid_d     = 1'b1;
				res_d.status    = err_q;
				res_d.last_bin  = 1'b1;
			end
			default: begin
				res_valid_d = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ibs_pkg::S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) req_q <= req;
		unique case (state_q)
			ibs_pkg::S_PRE: begin
				len_q <= {1'b0, req_q.site_end} - {1'b0, req_q.site_start} + LW'(1);
				if (req_q.site_end < req_q.site_start) err_q <= ibs_pkg::STAT_BAD;
				else if (req_q.amount == '0) err_q <= ibs_pkg::STAT_ZERO;
				else err_q <= ibs_pkg::STAT_OK;
			end
			ibs_pkg::S_LEN: begin
				if (err_q == ibs_pkg::STAT_OK && short_c) err_q <= ibs_pkg::STAT_SHORT;
			end
			ibs_pkg::S_DIV: begin
				if (div_res.done) begin
					if (strict_c) err_q <= ibs_pkg::STAT_STRICT;
					else if (many_c) err_q <= ibs_pkg::STAT_BAD;
					cur_q    <= {1'b0, req_q.site_start};
					size_q   <= size_c;
					nleft_q  <= count_c[CNT_W-1:0];
					extend_q <= rem_nz && req_q.policy == ibs_pkg::POL_EXTEND;
					extra_q  <= rem_nz && req_q.policy == ibs_pkg::POL_ADD;
				end
			end
			ibs_pkg::S_EMIT: begin
				cur_q   <= cur_q + size_q;
				nleft_q <= nleft_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// checks
	`ASSERT_CLK(a_err_is_last, clk, arst_n, res_valid && res.status != ibs_pkg::STAT_OK |-> res.last_bin, "error result without last mark")
	`ASSERT_CLK(a_last_ends_item, clk, arst_n, res_valid && res.last_bin |-> !busy, "last result while item still in work")
	`ASSERT_CLK(a_accept_busy, clk, arst_n, start && !busy |=> busy && !res_valid, "accepted item did not raise busy")

endmodule

`default_nettype wire

>>> verif/tb_interval_bin_splitter.sv
// ----------------------------------------------------------------------------
// tb_interval_bin_splitter
// self-checking bench for the interval bin splitter
//
// items go in through the start/busy handshake, and the bench works out on its
// own which bins each accepted item must give: equal splits, fixed-size cuts,
// the four leftover policies and every error code in its order of precedence.
// every result strobe is checked field by field against the oldest expected
// bin. a few directed items come first, then random bursts of mostly
// well-formed intervals with some noise.
// ----------------------------------------------------------------------------

module tb_interval_bin_splitter;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W      = ibs_pkg::COORD_W;
	localparam int LEN_W        = ibs_pkg::LEN_W;
	localparam int TAG_W        = ibs_pkg::TAG_W;
	localparam int STAT_W       = ibs_pkg::STAT_W;
	localparam int MAX_BINS     = ibs_pkg::MAX_BINS_DEF;
	localparam int RANDOM_ITEMS = 106;
	localparam int CYCLE_LIMIT  = 400000;
	// past the divider's work with some margin, so late strays are caught
	localparam int TAIL_CYCLES  = 48;
	localparam int unsigned COORD_MAX = 32'h7FFF_FFFF;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     start;
	logic     busy;
	ibs_pkg::ibs_req_t req;
	logic     res_valid;
	ibs_pkg::ibs_res_t res;

	// bins still owed by the block, oldest first
	ibs_pkg::ibs_res_t pending_bins[$];

	int fails         = 0;
	int items_sent    = 0;
	int bins_seen     = 0;
	int error_results = 0;
	int cycles        = 0;

	interval_bin_splitter #(
		.MAX_BINS(MAX_BINS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.res_valid(res_valid),
		.res      (res)
	);

	always #2 clk = ~clk;

	// watchdog: a hung block or a lost bin ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d bins outstanding", $time, pending_bins.size());
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// bin prediction
	// ------------------------------------------------------------------------

	// appends one owed bin at the tail of the queue
	function automatic void owe_bin(ibs_pkg::ibs_res_t r);
		pending_bins = {pending_bins, r};
	endfunction

	// an error item gives one flagged result with zero coordinates
	function automatic void push_error(ibs_pkg::ibs_req_t it, logic [STAT_W-1:0] code);
		ibs_pkg::ibs_res_t r;
		r          = '0;
		r.bin_tag  = it.chrom_tag;
		r.status   = code;
		r.last_bin = 1'b1;
		owe_bin(r);
	endfunction

	// works out every bin an accepted item must produce, in order
	function automatic void predict_bins(ibs_pkg::ibs_req_t it);
		logic [LEN_W:0] len;
		logic [LEN_W:0] amt;
		logic [LEN_W:0] one;
		logic [LEN_W:0] size;
		logic [LEN_W:0] count;
		logic [LEN_W:0] rem;
		logic [LEN_W:0] cur;
		int             nbins;
		logic           stretch_last;
		logic           extra_bin;
		ibs_pkg::ibs_res_t r;
		amt = {2'b00, it.amount};
		one = {{LEN_W{1'b0}}, 1'b1};
		// checks in order of precedence: inverted, zero, short, strict, too many
		if (it.site_end < it.site_start) begin
			push_error(it, ibs_pkg::STAT_BAD);
		end else if (it.amount == '0) begin
			push_error(it, ibs_pkg::STAT_ZERO);
		end else begin
			len = {2'b00, it.site_end} - {2'b00, it.site_start} + one;
			if (len < amt) begin
				push_error(it, ibs_pkg::STAT_SHORT);
			end else begin
				if (it.op == ibs_pkg::OP_COUNT) begin
					count = amt;
					size  = len / amt;
				end else begin
					size  = amt;
					count = len / amt;
				end
				rem = len % amt;
				if (it.policy == ibs_pkg::POL_STRICT && rem != '0) begin
					push_error(it, ibs_pkg::STAT_STRICT);
				end else if (count > (LEN_W+1)'(MAX_BINS)) begin
					push_error(it, ibs_pkg::STAT_BAD);
				end else begin
					stretch_last = (rem != '0) && (it.policy == ibs_pkg::POL_EXTEND);
					extra_bin    = (rem != '0) && (it.policy == ibs_pkg::POL_ADD);
					nbins     = int'(count);
					r         = '0;
					r.bin_tag = it.chrom_tag;
					r.status  = ibs_pkg::STAT_OK;
					cur       = {2'b00, it.site_start};
					for (int i = 0; i < nbins; i++) begin
						r.bin_start = COORD_W'(cur);
						r.bin_end   = COORD_W'(cur + size - one);
						r.last_bin  = 1'b0;
						if (i == nbins - 1) begin
							if (stretch_last)
								r.bin_end = it.site_end;
							r.last_bin = !extra_bin;
						end
						owe_bin(r);
						cur = cur + size;
					end
					// leftover goes into one more bin up to the interval end
					if (extra_bin) begin
						r.bin_start = COORD_W'(cur);
						r.bin_end   = it.site_end;
						r.last_bin  = 1'b1;
						owe_bin(r);
					end
				end
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
			fails++;
		end
	endfunction

	// a result is on res for the one cycle that ends at this edge
	always @(posedge clk) begin : result_check
		ibs_pkg::ibs_res_t want;
		if (arst_n && res_valid) begin
			bins_seen++;
			if (res.status != ibs_pkg::STAT_OK)
				error_results++;
			if (pending_bins.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual %p", $time, res);
				fails++;
			end else begin
				want = pending_bins.pop_front();
				check_field("bin_start", 32'(want.bin_start), 32'(res.bin_start));
				check_field("bin_end",   32'(want.bin_end),   32'(res.bin_end));
				check_field("bin_tag",   32'(want.bin_tag),   32'(res.bin_tag));
				check_field("status",    32'(want.status),    32'(res.status));
				check_field("last_bin",  32'(want.last_bin),  32'(res.last_bin));
			end
		end
	end

	// ------------------------------------------------------------------------
	// item driving
	// ------------------------------------------------------------------------

	// leaves start high on return: the caller sends again or idles in the same step
	task automatic send_item(input ibs_pkg::ibs_req_t it);
		req   <= it;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		// taken at this edge: start high, busy low
		predict_bins(it);
		items_sent++;
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n < 1 ? 1 : n)
			@(posedge clk);
	endtask

	// hold off the sender until every owed bin has come out
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_bins.size() != 0);
	endtask

	function automatic ibs_pkg::ibs_req_t make_req(logic op, int unsigned s, int unsigned e,
	                                               int unsigned amt, logic [1:0] pol,
	                                               logic [TAG_W-1:0] tag);
		ibs_pkg::ibs_req_t it;
		it.op         = op;
		it.site_start = COORD_W'(s);
		it.site_end   = COORD_W'(e);
		it.amount     = COORD_W'(amt);
		it.policy     = pol;
		it.chrom_tag  = tag;
		return it;
	endfunction

	// mostly well-formed intervals built from a bin count, a bin size and a
	// leftover; one in five is noise that lands on the error paths
	function automatic ibs_pkg::ibs_req_t random_item();
		ibs_pkg::ibs_req_t it;
		logic [31:0] cnt;
		logic [31:0] sz;
		logic [31:0] rem;
		logic [31:0] len;
		logic [31:0] room;
		logic [31:0] s;
		it.op        = 1'($urandom_range(0, 1));
		it.policy    = 2'($urandom_range(0, 3));
		it.chrom_tag = TAG_W'($urandom_range(0, 255));
		if ($urandom_range(0, 4) == 0) begin
			if ($urandom_range(0, 1) == 0) begin
				// full-width noise, mostly inverted or far too many bins
				it.site_start = COORD_W'($urandom);
				it.site_end   = COORD_W'($urandom);
				it.amount     = COORD_W'($urandom);
			end else begin
				// short intervals: zero amounts, too-short and strict leftovers
				it.site_start = COORD_W'($urandom_range(0, 100));
				it.site_end   = COORD_W'($urandom_range(0, 100));
				it.amount     = COORD_W'($urandom_range(0, 120));
			end
		end else begin
			case ($urandom_range(0, 3))
				0: cnt = $urandom_range(1, 4);
				1: cnt = $urandom_range(58, 68);
				default: cnt = $urandom_range(1, 63);
			endcase
			if ($urandom_range(0, 7) == 0)
				sz = $urandom_range(1, 1 << 24);
			else
				sz = $urandom_range(1, 200);
			if ($urandom_range(0, 2) == 0)
				rem = 0;
			else if (it.op == ibs_pkg::OP_COUNT)
				rem = $urandom_range(0, cnt - 1);
			else
				rem = $urandom_range(0, sz - 1);
			len       = cnt * sz + rem;
			it.amount = (it.op == ibs_pkg::OP_COUNT) ? COORD_W'(cnt) : COORD_W'(sz);
			room      = 32'h8000_0000 - len;
			// sometimes flush against the top of the coordinate range
			s = ($urandom_range(0, 5) == 0) ? room : $urandom_range(0, room);
			it.site_start = COORD_W'(s);
			it.site_end   = COORD_W'(s + len - 1);
		end
		return it;
	endfunction

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// each error code, and which one wins when several apply
	task automatic test_error_codes();
		// inverted beats zero
		send_item(make_req(ibs_pkg::OP_COUNT, 100, 99, 0, ibs_pkg::POL_STRICT, 8'h01));
		// zero amount
		send_item(make_req(ibs_pkg::OP_SIZE, 0, 9, 0, ibs_pkg::POL_EXTEND, 8'h02));
		// too short, count
		send_item(make_req(ibs_pkg::OP_COUNT, 10, 14, 6, ibs_pkg::POL_ADD, 8'h03));
		// too short beats strict
		send_item(make_req(ibs_pkg::OP_SIZE, 10, 14, 6, ibs_pkg::POL_STRICT, 8'h04));
		// strict leftover
		send_item(make_req(ibs_pkg::OP_COUNT, 0, 9, 3, ibs_pkg::POL_STRICT, 8'h05));
		// too many bins, count
		send_item(make_req(ibs_pkg::OP_COUNT, 0, 999, 64, ibs_pkg::POL_IGNORE, 8'h06));
		// too many bins, size
		send_item(make_req(ibs_pkg::OP_SIZE, 0, 63, 1, ibs_pkg::POL_ADD, 8'h07));
		// strict beats too many
		send_item(make_req(ibs_pkg::OP_COUNT, 0, 999, 64, ibs_pkg::POL_STRICT, 8'h08));
		wait_drained();
	endtask

	// extend, add and ignore with a leftover for both operations; strict and add without one
	task automatic test_leftover_policies();
		send_item(make_req(ibs_pkg::OP_COUNT, 1000, 1009, 3, ibs_pkg::POL_EXTEND, 8'h10));
		send_item(make_req(ibs_pkg::OP_COUNT, 1000, 1009, 3, ibs_pkg::POL_ADD, 8'h11));
		send_item(make_req(ibs_pkg::OP_COUNT, 1000, 1009, 3, ibs_pkg::POL_IGNORE, 8'h12));
		send_item(make_req(ibs_pkg::OP_SIZE, 1000, 1009, 4, ibs_pkg::POL_EXTEND, 8'h13));
		send_item(make_req(ibs_pkg::OP_SIZE, 1000, 1009, 4, ibs_pkg::POL_ADD, 8'h14));
		send_item(make_req(ibs_pkg::OP_SIZE, 1000, 1009, 4, ibs_pkg::POL_IGNORE, 8'h15));
		// no leftover: strict passes and add gives no extra bin
		send_item(make_req(ibs_pkg::OP_SIZE, 1000, 1009, 5, ibs_pkg::POL_STRICT, 8'h16));
		send_item(make_req(ibs_pkg::OP_COUNT, 1000, 1009, 5, ibs_pkg::POL_ADD, 8'h17));
		wait_drained();
	endtask

	// field extremes and the largest result count
	task automatic test_extremes();
		// full range split into the most bins plus an extra one
		send_item(make_req(ibs_pkg::OP_COUNT, 0, COORD_MAX, MAX_BINS, ibs_pkg::POL_ADD, 8'hFF));
		send_item(make_req(ibs_pkg::OP_SIZE, 0, COORD_MAX, COORD_MAX, ibs_pkg::POL_ADD, 8'h80));
		send_item(make_req(ibs_pkg::OP_SIZE, COORD_MAX, COORD_MAX, 1, ibs_pkg::POL_STRICT,
		                   8'hFF));
		send_item(make_req(ibs_pkg::OP_COUNT, COORD_MAX - 62, COORD_MAX, MAX_BINS,
		                   ibs_pkg::POL_IGNORE, 8'h7F));
		send_item(make_req(ibs_pkg::OP_SIZE, 0, COORD_MAX, COORD_MAX, ibs_pkg::POL_STRICT,
		                   8'h55));
		send_item(make_req(ibs_pkg::OP_COUNT, 0, COORD_MAX, COORD_MAX, ibs_pkg::POL_EXTEND,
		                   8'hAA));
		send_item(make_req(ibs_pkg::OP_SIZE, COORD_MAX, 0, COORD_MAX, ibs_pkg::POL_IGNORE,
		                   8'h00));
		send_item(make_req(ibs_pkg::OP_COUNT, 5, 5, 1, ibs_pkg::POL_IGNORE, 8'h00));
		wait_drained();
	endtask

	// random bursts; gaps land on every stage of the block's work, and now
	// and then the sender holds off until the block has drained
	task automatic test_random_bursts(input int n);
		int sent;
		int burst;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 8);
			for (int i = 0; i < burst && sent < n; i++) begin
				send_item(random_item());
				sent++;
			end
			case ($urandom_range(0, 9))
				0: wait_drained();
				1: idle_cycles($urandom_range(60, 120));
				default: idle_cycles($urandom_range(1, 50));
			endcase
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------------
	// run
	// ------------------------------------------------------------------------

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		req    <= '0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_error_codes();
		test_leftover_policies();
		test_extremes();
		test_random_bursts(RANDOM_ITEMS);

		// nothing owed any more; watch a while for stray strobes
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (pending_bins.size() != 0) begin
			$display("%0t ns: %0d expected bins never came", $time, pending_bins.size());
			fails++;
		end

		$display("covered %0d items: error precedence, all policies, count and size splits",
		         items_sent);
		$display("checked %0d results, %0d of them error results, %0d mismatches",
		         bins_seen, error_results, fails);
		if (fails == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
